>>> rtl/core/histeq_pkg.sv
// Shared types and constants for the histogram equalizer.
`default_nettype none
package histeq_pkg;
    localparam int unsigned CountW = 25;
    localparam int unsigned SizeW = 13;
    localparam int unsigned PixW = 8;
    localparam int unsigned AreaW = 2 * SizeW;
    localparam int unsigned ProdW = CountW + PixW;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [PixW-1:0] GrayMax = 8'd255;
    localparam logic OpCount = 1'b0;
    localparam logic OpMap = 1'b1;
    localparam logic RegWidth = 1'b0;
    localparam logic RegHeight = 1'b1;

    typedef struct packed {
        logic                start;
        logic [ProdW-1:0]    dividend;
        logic [AreaW-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ProdW-1:0]    quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> rtl/core/histogram_equalizer.sv
// Top level of the two-pass histogram equalizer with its sequencer and memories.
`default_nettype none
// A count word (operation 0) reads its bin, then writes it back.
// A map word reads the table, then loads the result into the
// output register, waiting there while an earlier result is still unaccepted.
// After reset a clearing pass over every bin zeroes the histogram and the
// table before the first word is taken. The last count word starts the table
// build, which per bin reads the bin, adds it to the running total, multiplies
// by 255 and divides by the frame area in a single one-bit-per-cycle divider,
// while the bin is cleared as it is read.
module histogram_equalizer #(
    parameter int unsigned GRAY_LEVELS = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire        i_operation,
    input  wire [7:0]  i_pixel,
    input  wire        i_last_pixel,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_pixel_out,
    output logic       o_last_out,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [12:0] i_cfg_data
);
    localparam int unsigned IdxW = $clog2(GRAY_LEVELS);
    localparam int unsigned CountW = histeq_pkg::CountW;
    localparam int unsigned SizeW = histeq_pkg::SizeW;
    localparam int unsigned AreaW = histeq_pkg::AreaW;
    localparam int unsigned ProdW = histeq_pkg::ProdW;
    localparam logic [IdxW-1:0] TopIdx = IdxW'(GRAY_LEVELS - 1);

    localparam logic [3:0] StClear  = 4'd0;
    localparam logic [3:0] StIdle   = 4'd1;
    localparam logic [3:0] StCntRd  = 4'd2;
    localparam logic [3:0] StCntWr  = 4'd3;
    localparam logic [3:0] StMapRd  = 4'd4;
    localparam logic [3:0] StMapOut = 4'd5;
    localparam logic [3:0] StBldRd  = 4'd6;
    localparam logic [3:0] StBldAdd = 4'd7;
    localparam logic [3:0] StBldMul = 4'd8;
    localparam logic [3:0] StBldDiv = 4'd9;
    localparam logic [3:0] StBldWr  = 4'd10;

    logic [CountW-1:0] r_bins [GRAY_LEVELS];
    logic [7:0]        r_table [GRAY_LEVELS];
    logic [CountW-1:0] r_bin_rd;
    logic [7:0]        r_tab_rd;

    logic [3:0]        r_state, n_state;
    logic [IdxW-1:0]   r_idx, n_idx;
    logic              r_last, n_last;
    logic [SizeW-1:0]  r_width, r_height;
    logic [CountW-1:0] r_total, n_total;
    logic [AreaW-1:0]  r_area;
    logic [ProdW-1:0]  r_prod;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_opix;
    logic              r_olast;
    logic [IdxW-1:0]   w_pix_idx;
    logic [CountW:0]   w_sum;
    logic [CountW-1:0] w_inc;
    logic              w_bin_we;
    logic [CountW-1:0] w_bin_wd;
    logic              w_tab_we;
    logic [7:0]        w_tab_wd;
    logic [SizeW-1:0]  w_w, w_h;
    histeq_pkg::t_div_req w_req;
    histeq_pkg::t_div_rsp w_rsp;

    histeq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        if (i_pixel >= 8'(GRAY_LEVELS - 1) || GRAY_LEVELS > 256) begin
            w_pix_idx = (GRAY_LEVELS > 256) ? IdxW'(i_pixel) : TopIdx;
        end else begin
            w_pix_idx = IdxW'(i_pixel);
        end
    end

    assign w_w = (r_width == '0) ? SizeW'(1) : r_width;
    assign w_h = (r_height == '0) ? SizeW'(1) : r_height;
    assign w_sum = {1'b0, r_total} + {1'b0, r_bin_rd};
    assign w_inc = (r_bin_rd == histeq_pkg::CountMax) ? r_bin_rd : r_bin_rd + 1'b1;

    assign o_ready = (r_state == StIdle);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_last = r_last;
        n_total = r_total;
        n_ovalid = r_ovalid;
        w_bin_we = 1'b0;
        w_bin_wd = '0;
        w_tab_we = 1'b0;
        w_tab_wd = '0;
        w_req.start = 1'b0;
        w_req.dividend = r_prod;
        w_req.divisor = r_area;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            StClear: begin
                w_bin_we = 1'b1;
                w_tab_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == TopIdx) begin
                    n_state = StIdle;
                    n_idx = '0;
                end
            end
            StIdle: begin
                if (i_valid && o_ready) begin
                    n_idx = w_pix_idx;
                    n_last = i_last_pixel;
                    n_state = (i_operation == histeq_pkg::OpMap) ? StMapRd : StCntRd;
                end
            end
            StCntRd: n_state = StCntWr;
            StCntWr: begin
                w_bin_we = 1'b1;
                w_bin_wd = w_inc;
                if (r_last) begin
                    n_state = StBldRd;
                    n_idx = '0;
                    n_total = '0;
                end else begin
                    n_state = StIdle;
                end
            end
            StMapRd: n_state = StMapOut;
            StMapOut: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_state = StIdle;
                end
            end
            StBldRd: n_state = StBldAdd;
            StBldAdd: begin
                w_bin_we = 1'b1;
                n_total = w_sum[CountW] ? histeq_pkg::CountMax : w_sum[CountW-1:0];
                n_state = StBldMul;
            end
            StBldMul: begin
                w_req.start = 1'b1;
                n_state = StBldDiv;
            end
            StBldDiv: begin
                if (w_rsp.done) begin
                    n_state = StBldWr;
                end
            end
            StBldWr: begin
                w_tab_we = 1'b1;
                w_tab_wd = (w_rsp.quotient > ProdW'(histeq_pkg::GrayMax)) ?
                           histeq_pkg::GrayMax : w_rsp.quotient[7:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == TopIdx) begin
                    n_state = StIdle;
                    n_idx = '0;
                end else begin
                    n_state = StBldRd;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_bin_we) begin
            r_bins[r_idx] <= w_bin_wd;
        end
        r_bin_rd <= r_bins[r_idx];
        if (w_tab_we) begin
            r_table[r_idx] <= w_tab_wd;
        end
        r_tab_rd <= r_table[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StClear;
            r_idx <= '0;
            r_last <= 1'b0;
            r_total <= '0;
            r_ovalid <= 1'b0;
            r_width <= SizeW'(512);
            r_height <= SizeW'(512);
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_last <= n_last;
            r_total <= n_total;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == histeq_pkg::RegWidth) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data;
                end
            end
        end
        r_area <= w_w * w_h;
        r_prod <= ProdW'(n_total) * ProdW'(histeq_pkg::GrayMax);
        if (r_state == StMapOut && (!r_ovalid || i_ready)) begin
            r_opix <= r_tab_rd;
            r_olast <= r_last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_pixel_out = r_opix;
    assign o_last_out = r_olast;

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == StIdle) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_opix))
        else $error("result word dropped");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == StBldDiv) else $error("stray divider done");
endmodule
`default_nettype wire

>>> rtl/core/histeq_div.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module histeq_div (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  histeq_pkg::t_div_req     i_req,
    output histeq_pkg::t_div_rsp     o_rsp
);
    localparam int unsigned ProdW = histeq_pkg::ProdW;
    localparam int unsigned AreaW = histeq_pkg::AreaW;
    localparam int unsigned CntW = $clog2(ProdW + 1);

    logic [ProdW-1:0] r_quo, n_quo;
    logic [AreaW:0]   r_rem, n_rem;
    logic [AreaW-1:0] r_dvs, n_dvs;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [AreaW:0]   w_shift;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem[AreaW-1:0], r_quo[ProdW-1]};
        if (i_req.start) begin
            n_quo = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
            n_cnt = CntW'(ProdW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_dvs}) begin
                n_rem = w_shift - {1'b0, r_dvs};
                n_quo = {r_quo[ProdW-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[ProdW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire
